// ===== design/assert_macros.svh =====
// Assertion macros used by the timer queue datapath.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that holds at every clock edge outside reset.
`define DTQ_ASSERT_ALWAYS(name, clk, rst, expr, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// A condition that, once seen, implies another in the next cycle.
`define DTQ_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/dtq_pkg.sv =====
// Types and constants of the deadline timer queue.
package dtq_pkg;

   localparam int NUM_TIMERS_DEF = 16;
   localparam int NS_PER_US = 1000;
   localparam int LEFT_W = 31;
   localparam int PROD_W = 42;
   localparam int DIV_W = 41;
   localparam int DIV_PRE = 3;
   localparam int QX_W = 38;
   localparam int HALF_W = 19;
   localparam int PART_W = 58;
   localparam int ACC_W = 77;
   localparam int RCP_SH = 45;
   localparam logic [38:0] RCP_125 = 39'd281474976711;
   localparam logic [LEFT_W-1:0] SAT_LEFT = 31'h7FFF_FFFF;
   localparam logic [63:0] SAT_LIMIT_NS = 64'd2147483648000;

   typedef enum logic [2:0] {
      CODE_START   = 3'd0,
      CODE_STOP    = 3'd1,
      CODE_SETP    = 3'd2,
      CODE_CLRP    = 3'd3,
      CODE_SCHED   = 3'd4,
      CODE_REMAIN  = 3'd5,
      CODE_NEAREST = 3'd6,
      CODE_NONE    = 3'd7
   } dtq_code_type;

   typedef enum logic [1:0] {
      RSP_OK   = 2'd0,
      RSP_BUSY = 2'd1,
      RSP_NONE = 2'd2
   } dtq_rsp_code_type;

   typedef enum logic [1:0] {
      SCAN_DUE  = 2'd0,
      SCAN_MIN  = 2'd1,
      SCAN_NEAR = 2'd2
   } dtq_scan_type;

   typedef enum logic [1:0] {
      RD_SCAN = 2'd0,
      RD_ID   = 2'd1,
      RD_BEST = 2'd2
   } dtq_rd_type;

   typedef enum logic {
      MUL_REQ = 1'b0,
      MUL_RD  = 1'b1
   } dtq_mul_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DISPATCH,
      S_EXEC,
      S_DUE_SCAN,
      S_MIN_SCAN,
      S_EXPIRE,
      S_REARM_MUL,
      S_REARM_WR,
      S_NEAR_SCAN,
      S_DIV_CHK,
      S_DIV_RUN
   } dtq_state_type;

   typedef struct packed {
      logic [2:0]  req_type;
      logic [3:0]  timer_id;
      logic [31:0] interval_us;
      logic [63:0] now_ns;
   } dtq_req_type;

   typedef struct packed {
      logic [1:0]        status;
      logic              is_expiry;
      logic [3:0]        expired_id;
      logic [LEFT_W-1:0] time_left_us;
      logic              last;
   } dtq_rsp_type;

   typedef struct packed {
      logic             latch;
      logic             scan_init;
      logic             scan_en;
      dtq_scan_type     scan_mode;
      dtq_rd_type       rd_sel;
      dtq_mul_type      mul_src;
      logic             start_wr;
      logic             stop;
      logic             set_periodic;
      logic             clr_periodic;
      logic             expire;
      logic             rearm;
      logic             div_load;
      logic             div_src_best;
      logic             div_chk;
      logic             div_step;
      logic             emit;
      dtq_rsp_code_type rsp_status;
      logic             rsp_expiry;
      logic             rsp_left;
      logic             rsp_last;
   } dtq_cmd_type;

   typedef struct packed {
      dtq_code_type code;
      logic         id_ok;
      logic         id_running;
      logic         scan_done;
      logic         best_vld;
      logic         div_done;
   } dtq_status_type;

endpackage

// ===== design/dtq_ctrl.sv =====
// Controller state machine of the deadline timer queue.
module dtq_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  dtq_pkg::dtq_status_type stat,
   output dtq_pkg::dtq_cmd_type    cmd
);

   dtq_pkg::dtq_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dtq_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      cmd.scan_mode = dtq_pkg::SCAN_DUE;
      cmd.rd_sel = dtq_pkg::RD_SCAN;
      cmd.mul_src = dtq_pkg::MUL_REQ;
      cmd.rsp_status = dtq_pkg::RSP_OK;
      busy = (state_ff != dtq_pkg::S_IDLE);
      unique case (state_ff)
         dtq_pkg::S_IDLE: begin
            if (start) begin
               cmd.latch = 1'b1;
               state_in = dtq_pkg::S_DISPATCH;
            end
         end
         dtq_pkg::S_DISPATCH: begin
            cmd.rd_sel = dtq_pkg::RD_ID;
            unique case (stat.code) inside
               dtq_pkg::CODE_NONE: begin
                  state_in = dtq_pkg::S_IDLE;
               end
               dtq_pkg::CODE_SCHED: begin
                  cmd.scan_init = 1'b1;
                  state_in = dtq_pkg::S_DUE_SCAN;
               end
               dtq_pkg::CODE_NEAREST: begin
                  cmd.scan_init = 1'b1;
                  state_in = dtq_pkg::S_NEAR_SCAN;
               end
               dtq_pkg::CODE_START, dtq_pkg::CODE_REMAIN: begin
                  if (stat.id_ok) begin
                     state_in = dtq_pkg::S_EXEC;
                  end else begin
                     cmd.emit = 1'b1;
                     cmd.rsp_status = dtq_pkg::RSP_NONE;
                     cmd.rsp_last = 1'b1;
                     state_in = dtq_pkg::S_IDLE;
                  end
               end
               default: begin
                  cmd.emit = 1'b1;
                  cmd.rsp_last = 1'b1;
                  state_in = dtq_pkg::S_IDLE;
                  if (!stat.id_ok) begin
                     cmd.rsp_status = dtq_pkg::RSP_NONE;
                  end else begin
                     cmd.stop = (stat.code == dtq_pkg::CODE_STOP);
                     cmd.set_periodic = (stat.code == dtq_pkg::CODE_SETP);
                     cmd.clr_periodic = (stat.code == dtq_pkg::CODE_CLRP);
                  end
               end
            endcase
         end
         dtq_pkg::S_EXEC: begin
            if (stat.code == dtq_pkg::CODE_START) begin
               cmd.emit = 1'b1;
               cmd.rsp_last = 1'b1;
               state_in = dtq_pkg::S_IDLE;
               if (stat.id_running) begin
                  cmd.rsp_status = dtq_pkg::RSP_BUSY;
               end else begin
                  cmd.start_wr = 1'b1;
               end
            end else if (stat.id_running) begin
               cmd.div_load = 1'b1;
               state_in = dtq_pkg::S_DIV_CHK;
            end else begin
               cmd.emit = 1'b1;
               cmd.rsp_last = 1'b1;
               state_in = dtq_pkg::S_IDLE;
            end
         end
         dtq_pkg::S_DUE_SCAN: begin
            cmd.scan_en = 1'b1;
            cmd.scan_mode = dtq_pkg::SCAN_DUE;
            if (stat.scan_done) begin
               cmd.scan_init = 1'b1;
               state_in = dtq_pkg::S_MIN_SCAN;
            end
         end
         dtq_pkg::S_MIN_SCAN: begin
            cmd.scan_en = 1'b1;
            cmd.scan_mode = dtq_pkg::SCAN_MIN;
            if (stat.scan_done) begin
               if (stat.best_vld) begin
                  state_in = dtq_pkg::S_EXPIRE;
               end else begin
                  cmd.scan_init = 1'b1;
                  state_in = dtq_pkg::S_NEAR_SCAN;
               end
            end
         end
         dtq_pkg::S_EXPIRE: begin
            cmd.expire = 1'b1;
            cmd.rd_sel = dtq_pkg::RD_BEST;
            cmd.emit = 1'b1;
            cmd.rsp_expiry = 1'b1;
            state_in = dtq_pkg::S_REARM_MUL;
         end
         dtq_pkg::S_REARM_MUL: begin
            cmd.mul_src = dtq_pkg::MUL_RD;
            state_in = dtq_pkg::S_REARM_WR;
         end
         dtq_pkg::S_REARM_WR: begin
            cmd.rearm = 1'b1;
            cmd.scan_init = 1'b1;
            state_in = dtq_pkg::S_MIN_SCAN;
         end
         dtq_pkg::S_NEAR_SCAN: begin
            cmd.scan_en = 1'b1;
            cmd.scan_mode = dtq_pkg::SCAN_NEAR;
            if (stat.scan_done) begin
               if (stat.best_vld) begin
                  cmd.div_load = 1'b1;
                  cmd.div_src_best = 1'b1;
                  state_in = dtq_pkg::S_DIV_CHK;
               end else begin
                  cmd.emit = 1'b1;
                  cmd.rsp_status = dtq_pkg::RSP_NONE;
                  cmd.rsp_last = 1'b1;
                  state_in = dtq_pkg::S_IDLE;
               end
            end
         end
         dtq_pkg::S_DIV_CHK: begin
            cmd.div_chk = 1'b1;
            state_in = dtq_pkg::S_DIV_RUN;
         end
         dtq_pkg::S_DIV_RUN: begin
            cmd.div_step = 1'b1;
            if (stat.div_done) begin
               cmd.emit = 1'b1;
               cmd.rsp_left = 1'b1;
               cmd.rsp_last = 1'b1;
               state_in = dtq_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = dtq_pkg::S_IDLE;
         end
      endcase
   end

endmodule

// ===== design/dtq_dp.sv =====
// Datapath of the deadline timer queue: timer storage, scan unit and divider.
`include "assert_macros.svh"

module dtq_dp #(
   parameter int NUM_TIMERS = dtq_pkg::NUM_TIMERS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  dtq_pkg::dtq_req_type    req_data,
   input  dtq_pkg::dtq_cmd_type    cmd,
   output dtq_pkg::dtq_status_type stat,
   output logic                    rsp_valid,
   output dtq_pkg::dtq_rsp_type    rsp_data
);

   localparam int IDX_W = $clog2(NUM_TIMERS);
   localparam int CNT_W = $clog2(NUM_TIMERS + 1);
   localparam int DCNT_W = 2;

   logic [63:0] dl_mem [NUM_TIMERS];
   logic [31:0] ivl_mem [NUM_TIMERS];

   dtq_pkg::dtq_req_type req_ff;
   logic [NUM_TIMERS-1:0] running_ff, periodic_ff, due_ff, dlv_ff;

   logic [IDX_W-1:0] rd_addr, rd_idx_ff, id_idx;
   logic [63:0] rd_dl_ff, dl_eff;
   logic [31:0] rd_ivl_ff;
   logic [dtq_pkg::PROD_W-1:0] prod_ff;

   logic [CNT_W-1:0] scan_cnt_ff;
   logic rd_vld_ff, best_vld_ff;
   logic [IDX_W-1:0] best_idx_ff;
   logic [63:0] best_dl_ff;
   logic scan_sel;

   logic wr_en;
   logic [IDX_W-1:0] wr_addr;
   logic [63:0] wr_dl, start_base, div_src;

   logic [63:0] diff_ff;
   logic le_ff;
   logic [dtq_pkg::QX_W-1:0] qx_ff;
   logic [dtq_pkg::HALF_W-1:0] mul_half;
   logic [dtq_pkg::PART_W-1:0] part_ff;
   logic [dtq_pkg::ACC_W-1:0] acc_ff, acc_sum;
   logic [dtq_pkg::LEFT_W-1:0] quo_ff;
   logic [DCNT_W-1:0] div_cnt_ff;

   logic rsp_valid_ff;
   dtq_pkg::dtq_rsp_type rsp_ff;
   logic exp_seen;

   assign id_idx = IDX_W'(req_ff.timer_id);

   always_comb begin
      case (cmd.rd_sel)
         dtq_pkg::RD_ID: rd_addr = id_idx;
         dtq_pkg::RD_BEST: rd_addr = best_idx_ff;
         default: rd_addr = scan_cnt_ff[IDX_W-1:0];
      endcase
   end

   assign dl_eff = dlv_ff[rd_idx_ff] ? rd_dl_ff : 64'd0;
   assign start_base = (periodic_ff[id_idx] && dl_eff != 64'd0) ? dl_eff : req_ff.now_ns;

   always_comb begin
      wr_en = 1'b0;
      wr_addr = id_idx;
      wr_dl = start_base + 64'(prod_ff);
      if (cmd.start_wr) begin
         wr_en = 1'b1;
      end else if (cmd.rearm && periodic_ff[best_idx_ff]) begin
         wr_en = 1'b1;
         wr_addr = best_idx_ff;
         wr_dl = best_dl_ff + 64'(prod_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         dl_mem[wr_addr] <= wr_dl;
      end
      if (cmd.start_wr) begin
         ivl_mem[id_idx] <= req_ff.interval_us;
      end
      rd_dl_ff <= dl_mem[rd_addr];
      rd_ivl_ff <= ivl_mem[rd_addr];
      rd_idx_ff <= rd_addr;
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         req_ff <= req_data;
      end
      if (cmd.mul_src == dtq_pkg::MUL_RD) begin
         prod_ff <= dtq_pkg::PROD_W'(rd_ivl_ff) * dtq_pkg::PROD_W'(dtq_pkg::NS_PER_US);
      end else begin
         prod_ff <= dtq_pkg::PROD_W'(req_ff.interval_us) *
                    dtq_pkg::PROD_W'(dtq_pkg::NS_PER_US);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= '0;
         periodic_ff <= '0;
         dlv_ff <= '0;
      end else begin
         if (wr_en) begin
            running_ff[wr_addr] <= 1'b1;
            dlv_ff[wr_addr] <= 1'b1;
         end
         if (cmd.stop) begin
            running_ff[id_idx] <= 1'b0;
            periodic_ff[id_idx] <= 1'b0;
         end
         if (cmd.set_periodic) begin
            periodic_ff[id_idx] <= 1'b1;
         end
         if (cmd.clr_periodic) begin
            periodic_ff[id_idx] <= 1'b0;
         end
         if (cmd.expire) begin
            running_ff[best_idx_ff] <= 1'b0;
         end
      end
   end

   assign scan_sel = (cmd.scan_mode == dtq_pkg::SCAN_MIN) ? due_ff[rd_idx_ff]
                                                          : running_ff[rd_idx_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_cnt_ff <= '0;
         rd_vld_ff <= 1'b0;
         best_vld_ff <= 1'b0;
         due_ff <= '0;
      end else if (cmd.scan_init) begin
         scan_cnt_ff <= '0;
         rd_vld_ff <= 1'b0;
         best_vld_ff <= 1'b0;
      end else begin
         if (cmd.expire) begin
            due_ff[best_idx_ff] <= 1'b0;
         end
         if (cmd.scan_en) begin
            rd_vld_ff <= (scan_cnt_ff < CNT_W'(NUM_TIMERS));
            if (scan_cnt_ff < CNT_W'(NUM_TIMERS)) begin
               scan_cnt_ff <= scan_cnt_ff + CNT_W'(1);
            end
            if (rd_vld_ff) begin
               if (cmd.scan_mode == dtq_pkg::SCAN_DUE) begin
                  due_ff[rd_idx_ff] <= running_ff[rd_idx_ff] && (dl_eff <= req_ff.now_ns);
               end else if (scan_sel && (!best_vld_ff || dl_eff < best_dl_ff)) begin
                  best_vld_ff <= 1'b1;
                  best_idx_ff <= rd_idx_ff;
                  best_dl_ff <= dl_eff;
               end
            end
         end else begin
            rd_vld_ff <= 1'b0;
         end
      end
   end

   // The quotient by 1000 is taken as (diff / 8) / 125 by a reciprocal multiply,
   // one half of the dividend per step, then a final add of the two partial products.
   assign div_src = cmd.div_src_best ? best_dl_ff : dl_eff;
   assign mul_half = (div_cnt_ff == DCNT_W'(3)) ? qx_ff[dtq_pkg::HALF_W-1:0]
                                                : qx_ff[dtq_pkg::QX_W-1:dtq_pkg::HALF_W];
   assign acc_sum = acc_ff + {part_ff, {dtq_pkg::HALF_W{1'b0}}};

   always_ff @(posedge clock) begin
      if (reset) begin
         div_cnt_ff <= '0;
      end else begin
         if (cmd.div_load) begin
            diff_ff <= div_src - req_ff.now_ns;
            le_ff <= (div_src <= req_ff.now_ns);
         end
         if (cmd.div_chk) begin
            if (le_ff) begin
               quo_ff <= '0;
               div_cnt_ff <= '0;
            end else if (diff_ff >= dtq_pkg::SAT_LIMIT_NS) begin
               quo_ff <= dtq_pkg::SAT_LEFT;
               div_cnt_ff <= '0;
            end else begin
               qx_ff <= diff_ff[dtq_pkg::DIV_W-1:dtq_pkg::DIV_PRE];
               div_cnt_ff <= DCNT_W'(3);
            end
         end else if (cmd.div_step && div_cnt_ff != '0) begin
            part_ff <= dtq_pkg::PART_W'(mul_half) * dtq_pkg::PART_W'(dtq_pkg::RCP_125);
            if (div_cnt_ff == DCNT_W'(2)) begin
               acc_ff <= dtq_pkg::ACC_W'(part_ff);
            end
            if (div_cnt_ff == DCNT_W'(1)) begin
               quo_ff <= acc_sum[dtq_pkg::RCP_SH+dtq_pkg::LEFT_W-1:dtq_pkg::RCP_SH];
            end
            div_cnt_ff <= div_cnt_ff - DCNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.emit;
      end
      if (cmd.emit) begin
         rsp_ff.status <= cmd.rsp_status;
         rsp_ff.is_expiry <= cmd.rsp_expiry;
         rsp_ff.expired_id <= cmd.rsp_expiry ? 4'(best_idx_ff) : 4'd0;
         rsp_ff.time_left_us <= cmd.rsp_left ? quo_ff : '0;
         rsp_ff.last <= cmd.rsp_last;
      end
   end

   always_comb begin
      stat.code = dtq_pkg::dtq_code_type'(req_ff.req_type);
      stat.id_ok = (32'(req_ff.timer_id) < NUM_TIMERS);
      stat.id_running = running_ff[id_idx];
      stat.scan_done = (scan_cnt_ff == CNT_W'(NUM_TIMERS)) && !rd_vld_ff;
      stat.best_vld = best_vld_ff;
      stat.div_done = (div_cnt_ff == '0);
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;
   assign exp_seen = rsp_valid_ff && rsp_ff.is_expiry && !rsp_ff.last;

   `DTQ_ASSERT_ALWAYS(a_due_running, clock, reset, (due_ff & ~running_ff) == '0, "due not running")
   `DTQ_ASSERT_ALWAYS(a_running_valid, clock, reset, (running_ff & ~dlv_ff) == '0, "no deadline")
   `DTQ_ASSERT_NEXT(a_expire_clears, clock, reset, cmd.expire, exp_seen, "expiry not reported")

endmodule

// ===== design/deadline_timer_queue.sv =====
// Top level of the deadline timer queue: controller and datapath.
//
// A bank of NUM_TIMERS timers with 64-bit nanosecond deadlines. A request is
// taken on req_data at a rising clock edge where start is high and busy is low.
// Each result is shown on rsp_data for one cycle with rsp_valid high; the
// receiver cannot stall, and the block never waits on it. The last field marks
// the final result of a request; an unused request code gives no result.
// Stop, set periodic, clear periodic and bad timer indexes answer from the
// dispatch state, start from the state after it. Remaining divides the time
// left by 1000 with a three-step reciprocal multiply. Nearest scans the
// deadline memory one entry a cycle, then divides the time left of the
// nearest running timer, or answers none if no timer runs. Schedule first
// scans to mark due timers, then for each expired timer a search, an expiry
// result and a rearm if periodic, then a search that finds no more due
// timers, then a nearest search.
// Busy stays high until the last result of a request has been issued.
// Reset clears all timers and flags at once; the block is ready in the next cycle.
module deadline_timer_queue #(
   parameter int NUM_TIMERS = dtq_pkg::NUM_TIMERS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  dtq_pkg::dtq_req_type req_data,
   output logic                 rsp_valid,
   output dtq_pkg::dtq_rsp_type rsp_data
);

   dtq_pkg::dtq_cmd_type    cmd;
   dtq_pkg::dtq_status_type stat;

   dtq_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   dtq_dp #(
      .NUM_TIMERS (NUM_TIMERS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule
